// ----- hdl/ksm_pkg.sv -----
package ksm_pkg;

    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 32;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_byte;
    } cmd_word_t;

    typedef struct packed {
        logic                match_found;
        logic [OFFSET_W-1:0] match_start;
        logic [STATUS_W-1:0] status;
    } res_word_t;

endpackage

// ----- hdl/ksm_if.sv -----
interface ksm_cmd_if import ksm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface ksm_rsp_if import ksm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                match_found;
    logic [OFFSET_W-1:0] match_start;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output match_found, output match_start, output status,
                    input ready);
    modport sink (input valid, input match_found, input match_start, input status,
                  output ready);
endinterface

// ----- hdl/ksm_front.sv -----
module ksm_front import ksm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    ksm_cmd_if.sink   req,
    output logic      q_valid,
    output cmd_word_t q_word,
    input  logic      q_pop
);

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    cmd_word_t          entry_reg [QDEPTH];
    logic [QPW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]     count_reg, count_next;
    logic               push;
    cmd_word_t          in_word;

    assign req.ready = (count_reg != QCW'(QDEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign q_word    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        in_word.cmd       = req.cmd;
        in_word.data_byte = req.data_byte;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

// ----- hdl/ksm_back.sv -----
module ksm_back import ksm_pkg::*; #(
    parameter int MAX_PATTERN = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  cmd_word_t q_word,
    output logic      q_pop,
    ksm_rsp_if.source rsp
);

    localparam int PW = $clog2(MAX_PATTERN + 1);
    localparam int AW = $clog2(MAX_PATTERN);

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_TXT_WALK = 2'd1;
    localparam logic [1:0] ST_BLD_WALK = 2'd2;
    localparam logic [1:0] ST_BLD_FIN  = 2'd3;

    // pattern and failure entries, position p lives at address p-1
    logic [BYTE_W-1:0] pattern_mem [MAX_PATTERN];
    logic [PW-1:0]     fail_mem    [MAX_PATTERN];

    logic [1:0]          state_reg, state_next;
    logic [PW-1:0]       len_reg, len_next;
    logic [PW-1:0]       bpi_reg, bpi_next;
    logic [PW-1:0]       mi_reg, mi_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [PW-1:0]       j_reg, j_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic [BYTE_W-1:0]   last_reg, last_next;
    logic                res_valid_reg, res_valid_next;
    res_word_t           res_reg, res_next;
    logic [BYTE_W-1:0]   p_rd_reg;
    logic [PW-1:0]       f_rd_reg;

    logic                rd_en;
    logic [PW-1:0]       rd_pos, rd_pos_m1;
    logic                p_we, f_we;
    logic [PW-1:0]       w_pos, w_pos_m1;
    logic [BYTE_W-1:0]   p_wdata;
    logic [PW-1:0]       f_wdata;

    logic                slot_free;
    logic [PW-1:0]       k_pos;
    logic [PW-1:0]       first_pos;
    logic                walk_done;
    logic [PW-1:0]       walk_j;
    logic [PW-1:0]       walk_j_inc;
    logic [PW-1:0]       bld_j1;

    assign rsp.valid       = res_valid_reg;
    assign rsp.match_found = res_reg.match_found;
    assign rsp.match_start = res_reg.match_start;
    assign rsp.status      = res_reg.status;

    assign slot_free  = !res_valid_reg || rsp.ready;
    assign k_pos      = len_reg + 1'b1;
    assign rd_pos_m1  = rd_pos - 1'b1;
    assign w_pos_m1   = w_pos - 1'b1;
    assign walk_j_inc = walk_j + 1'b1;
    assign bld_j1     = (walk_j_inc >= k_pos) ? '0 : walk_j_inc;
    // text search resumes one past the current partial match
    assign first_pos  = (mi_reg + 1'b1 > len_reg) ? PW'(1) : mi_reg + 1'b1;

    // one failure-link step per cycle: compare the fetched byte, else chase its link
    always_comb
    begin
        walk_done = 1'b0;
        walk_j    = '0;
        if (((state_reg == ST_TXT_WALK) ? byte_reg : last_reg) == p_rd_reg)
        begin
            walk_done = 1'b1;
            walk_j    = j_reg;
        end
        else if (f_rd_reg == '0)
        begin
            walk_done = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        bpi_next       = bpi_reg;
        mi_next        = mi_reg;
        off_next       = off_reg;
        j_next         = j_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        res_valid_next = res_valid_reg && !rsp.ready;
        res_next       = res_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_pos         = '0;
        p_we           = 1'b0;
        f_we           = 1'b0;
        w_pos          = k_pos;
        p_wdata        = q_word.data_byte;
        f_wdata        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop                = 1'b1;
                    byte_next            = q_word.data_byte;
                    res_next.match_found = 1'b0;
                    res_next.match_start = '0;
                    res_next.status      = STAT_OK;
                    unique case (q_word.cmd)
                        CMD_CLEAR:
                        begin
                            len_next       = '0;
                            bpi_next       = '0;
                            mi_next        = '0;
                            res_valid_next = 1'b1;
                        end
                        CMD_RESTART:
                        begin
                            mi_next        = '0;
                            off_next       = '0;
                            res_valid_next = 1'b1;
                        end
                        CMD_APPEND:
                        begin
                            if (len_reg == PW'(MAX_PATTERN))
                            begin
                                res_next.status = STAT_FULL;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                p_we = 1'b1;
                                if (len_reg == '0)
                                begin
                                    f_we           = 1'b1;
                                    bpi_next       = '0;
                                    len_next       = k_pos;
                                    last_next      = q_word.data_byte;
                                    res_valid_next = 1'b1;
                                end
                                else if (bpi_reg == '0)
                                begin
                                    // no prefix to walk, candidate is position one
                                    bpi_next   = PW'(1);
                                    j_next     = PW'(1);
                                    rd_en      = 1'b1;
                                    rd_pos     = PW'(1);
                                    state_next = ST_BLD_FIN;
                                end
                                else
                                begin
                                    j_next     = bpi_reg;
                                    rd_en      = 1'b1;
                                    rd_pos     = bpi_reg;
                                    state_next = ST_BLD_WALK;
                                end
                            end
                        end
                        CMD_TEXT:
                        begin
                            if (len_reg == '0)
                            begin
                                res_next.status = STAT_EMPTY;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                j_next     = first_pos;
                                rd_en      = 1'b1;
                                rd_pos     = first_pos;
                                state_next = ST_TXT_WALK;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_TXT_WALK:
            begin
                if (walk_done)
                begin
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                    off_next       = off_reg + 1'b1;
                    if (walk_j >= len_reg)
                    begin
                        res_next.match_found = 1'b1;
                        res_next.match_start = off_reg - OFFSET_W'(len_reg) + 1'b1;
                        mi_next              = '0;
                    end
                    else
                    begin
                        mi_next = walk_j;
                    end
                end
                else
                begin
                    j_next = f_rd_reg;
                    rd_en  = 1'b1;
                    rd_pos = f_rd_reg;
                end
            end
            ST_BLD_WALK:
            begin
                if (walk_done)
                begin
                    bpi_next = bld_j1;
                    if (bld_j1 == '0)
                    begin
                        f_we           = 1'b1;
                        len_next       = k_pos;
                        last_next      = byte_reg;
                        res_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        j_next     = bld_j1;
                        rd_en      = 1'b1;
                        rd_pos     = bld_j1;
                        state_next = ST_BLD_FIN;
                    end
                end
                else
                begin
                    j_next = f_rd_reg;
                    rd_en  = 1'b1;
                    rd_pos = f_rd_reg;
                end
            end
            ST_BLD_FIN:
            begin
                // nextval: skip the candidate when it would compare the same byte again
                f_we           = 1'b1;
                f_wdata        = (byte_reg == p_rd_reg) ? f_rd_reg : j_reg;
                len_next       = k_pos;
                last_next      = byte_reg;
                res_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            bpi_reg       <= '0;
            mi_reg        <= '0;
            off_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            bpi_reg       <= bpi_next;
            mi_reg        <= mi_next;
            off_reg       <= off_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            p_rd_reg <= pattern_mem[rd_pos_m1[AW-1:0]];
            f_rd_reg <= fail_mem[rd_pos_m1[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pattern_mem[w_pos_m1[AW-1:0]] <= p_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fail_mem[w_pos_m1[AW-1:0]] <= f_wdata;
        end
    end

endmodule

// ----- hdl/kmp_stream_matcher_top.sv -----
// sequencing: each word is registered into the command queue; clear, restart, dropped and
// ignored words and an append to an empty pattern finish in the idle state of the sequencer;
// a text word walks failure links until a match or link zero, any other append walks prefix
// links and may then pass through the nextval step; the result word is registered
// throughput: one word per sequencer pass, taken only when the result slot is free; one
// failure link per cycle through the single-read pattern and link memories
// reset: pattern length, match state and text offset clear; memory contents are not cleared
module kmp_stream_matcher_top import ksm_pkg::*; #(
    parameter int MAX_PATTERN = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    ksm_cmd_if.sink   req,
    ksm_rsp_if.source rsp
);

    logic      q_valid;
    cmd_word_t q_word;
    logic      q_pop;

    ksm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop)
    );

    ksm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule
